FILE: sv/haversine_distance_unit_defines.svh
// ---------------------------------------------------------------------------
// Haversine distance unit - assertion macros
// Shared assertion forms for the modules that check their own logic.
// ---------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_UNIT_DEFINES_SVH
`define HAVERSINE_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hvd_pkg.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - package
// Fixed-point constants, the arctangent table and shared helper functions.
// ---------------------------------------------------------------------------
package hvd_pkg;

	// Angle and CORDIC datapath word: signed, 30 fraction bits.
	typedef logic signed [33:0] ang_t;

	// Control that travels alongside the front pipeline.
	typedef struct packed {
		logic valid;
		logic dlat_neg;
		logic dlon_neg;
		logic flip1;
		logic flip2;
	} fr_ctl_t;

	localparam logic [31:0]        PI_Q30        = 32'd3373259426;
	localparam logic signed [33:0] GAIN_Q30      = 34'sd652032874;
	localparam logic [30:0]        ONE_Q30       = 31'd1073741824;
	localparam logic [31:0]        HALF_TURN     = 32'd1800000000;
	localparam logic [31:0]        QUARTER_TURN  = 32'd900000000;
	localparam logic [31:0]        FULL_TURN     = 32'd3600000000;
	localparam logic signed [33:0] HALF_TURN_S   = 34'sd1800000000;
	localparam logic signed [33:0] FULL_TURN_S   = 34'sd3600000000;
	localparam logic [34:0]        OUT_MAX       = 35'h7_FFFF_FFFF;
	localparam logic [22:0]        RADIUS_RESET  = 23'd6371000;
	// floor(2^63 / FULL_TURN), the reciprocal used by the divider.
	localparam logic [31:0]        DIV_RECIP     = 32'd2562047788;
	localparam int                 QUEUE_DEPTH   = 4;
	localparam int                 QUEUE_AW      = 2;
	// Pipeline depth of the divider by a full turn.
	localparam int                 DIV_STEPS     = 4;
	localparam int                 SQRT_STEPS    = 31;

	// Arctangent of 2^-i in Q30.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Q30 product rounded half up.
	function automatic ang_t mul_q30(input ang_t a, input ang_t b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + 68'sd536870912;
		return 34'(p >>> 30);
	endfunction

endpackage

FILE: sv/hvd_cdiv.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - pipelined divider
// Division of a 63-bit numerator by a full turn, by reciprocal
// multiplication followed by a remainder correction, over four stages.
// ---------------------------------------------------------------------------
module hvd_cdiv (
	input  logic        clk,
	input  logic [62:0] num,
	output logic [31:0] quo
);

	logic [63:0] est_s1;
	logic [62:0] num_s1, num_s2;
	logic [31:0] q_s2, q_s3;
	logic [33:0] rem_s3;
	logic [31:0] quo_s4;

	// The estimate from the upper 32 numerator bits is at most two below the
	// true quotient, so the remainder stays under three divisors.
	always_ff @(posedge clk) begin
		est_s1 <= 64'(num[62:31]) * 64'(hvd_pkg::DIV_RECIP);
		num_s1 <= num;
		q_s2   <= est_s1[63:32];
		num_s2 <= num_s1;
		rem_s3 <= 34'(64'(num_s2) - 64'(q_s2) * 64'(hvd_pkg::FULL_TURN));
		q_s3   <= q_s2;
		priority if (rem_s3 >= {1'b0, hvd_pkg::FULL_TURN, 1'b0}) quo_s4 <= q_s3 + 32'd2;
		else if (rem_s3 >= {2'b00, hvd_pkg::FULL_TURN})          quo_s4 <= q_s3 + 32'd1;
		else                                                     quo_s4 <= q_s3;
	end

	assign quo = quo_s4;

endmodule

FILE: sv/hvd_rot.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - rotation CORDIC
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q30 angle.
// ---------------------------------------------------------------------------
module hvd_rot #(
	parameter int STAGES = 24
) (
	input  logic           clk,
	input  hvd_pkg::ang_t  ang,
	output hvd_pkg::ang_t  sn,
	output hvd_pkg::ang_t  cs
);

	hvd_pkg::ang_t x_s [0:STAGES];
	hvd_pkg::ang_t y_s [0:STAGES];
	hvd_pkg::ang_t z_s [0:STAGES];

	// Start on the x axis with the gain already removed.
	assign x_s[0] = hvd_pkg::GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = ang;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		hvd_pkg::ang_t at;

		assign at = $signed({2'b00, hvd_pkg::atan_q30(5'(i))});

		// Turn towards the residual angle by atan(2^-i).
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + at;
			end
		end
	end

	assign sn = y_s[STAGES];
	assign cs = x_s[STAGES];

endmodule

FILE: sv/hvd_front.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - front end
// Converts coordinates to Q30 angles, runs sine and cosine, and forms the
// haversine term a, clamped to [0, 1].
// ---------------------------------------------------------------------------
module hvd_front #(
	parameter int STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               push,
	output logic [30:0]        a_q30
);

	localparam int DIV_OUT = 1 + hvd_pkg::DIV_STEPS;
	localparam int ROT_OUT = DIV_OUT + STAGES;
	localparam int FL      = ROT_OUT + 4;

	hvd_pkg::fr_ctl_t ctl_q [0:FL-1];
	hvd_pkg::fr_ctl_t ctl_in;

	logic signed [33:0] dlat, dlon, lat1_x, lat2_x;
	logic [30:0] m_dlat, m_dlon, m_lat1, m_lat2;
	logic [30:0] m_dlat_s1, m_dlon_s1, m_lat1_s1, m_lat2_s1;
	logic [62:0] n_dlat_s2, n_dlon_s2, n_lat1_s2, n_lat2_s2;
	logic [31:0] h_dlat, h_dlon, h_lat1, h_lat2;
	hvd_pkg::ang_t ang_dlat, ang_dlon, ang_lat1, ang_lat2;
	hvd_pkg::ang_t sn_dlat, sn_dlon, cs_lat1, cs_lat2, c1, c2;
	hvd_pkg::ang_t s1sq_s1, s2sq_s1, cc_s1, s1sq_s2, t_s2;
	logic signed [34:0] a_sum;
	logic [30:0] a_s3;

	// Wrap a difference into the half-open turn around zero.
	function automatic logic signed [33:0] wrap(input logic signed [33:0] d);
		logic signed [33:0] r;
		priority if (d >= hvd_pkg::HALF_TURN_S) r = d - hvd_pkg::FULL_TURN_S;
		else if (d < -hvd_pkg::HALF_TURN_S)     r = d + hvd_pkg::FULL_TURN_S;
		else                                    r = d;
		return r;
	endfunction

	function automatic logic [30:0] mag(input logic signed [33:0] d);
		logic signed [33:0] r;
		r = (d < 0) ? -d : d;
		return r[30:0];
	endfunction

	// Differences, magnitudes and the latitude fold past a quarter turn.
	always_comb begin
		dlat   = wrap(34'(second_latitude) - 34'(first_latitude));
		dlon   = wrap(34'(second_longitude) - 34'(first_longitude));
		lat1_x = 34'(first_latitude);
		lat2_x = 34'(second_latitude);
		m_dlat = mag(dlat);
		m_dlon = mag(dlon);
		ctl_in.valid    = accept;
		ctl_in.dlat_neg = dlat < 0;
		ctl_in.dlon_neg = dlon < 0;
		ctl_in.flip1    = mag(lat1_x) > hvd_pkg::QUARTER_TURN[30:0];
		ctl_in.flip2    = mag(lat2_x) > hvd_pkg::QUARTER_TURN[30:0];
		m_lat1 = ctl_in.flip1 ? 31'(hvd_pkg::HALF_TURN - 32'(mag(lat1_x))) : mag(lat1_x);
		m_lat2 = ctl_in.flip2 ? 31'(hvd_pkg::HALF_TURN - 32'(mag(lat2_x))) : mag(lat2_x);
	end

	// Control pipeline alongside the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FL; k++) ctl_q[k] <= '0;
		end else begin
			ctl_q[0] <= ctl_in;
			for (int k = 1; k < FL; k++) ctl_q[k] <= ctl_q[k-1];
		end
	end

	// Register the magnitudes, then scale by pi with the rounding term.
	// Latitude terms are doubled so that every division is by a full turn.
	always_ff @(posedge clk) begin
		m_dlat_s1 <= m_dlat;
		m_dlon_s1 <= m_dlon;
		m_lat1_s1 <= m_lat1;
		m_lat2_s1 <= m_lat2;
		n_dlat_s2 <= 63'(m_dlat_s1) * 63'(hvd_pkg::PI_Q30) + 63'(hvd_pkg::HALF_TURN);
		n_dlon_s2 <= 63'(m_dlon_s1) * 63'(hvd_pkg::PI_Q30) + 63'(hvd_pkg::HALF_TURN);
		n_lat1_s2 <= 63'({m_lat1_s1, 1'b0}) * 63'(hvd_pkg::PI_Q30)
			+ 63'(hvd_pkg::HALF_TURN);
		n_lat2_s2 <= 63'({m_lat2_s1, 1'b0}) * 63'(hvd_pkg::PI_Q30)
			+ 63'(hvd_pkg::HALF_TURN);
	end

	hvd_cdiv u_div_dlat (.clk, .num(n_dlat_s2), .quo(h_dlat));
	hvd_cdiv u_div_dlon (.clk, .num(n_dlon_s2), .quo(h_dlon));
	hvd_cdiv u_div_lat1 (.clk, .num(n_lat1_s2), .quo(h_lat1));
	hvd_cdiv u_div_lat2 (.clk, .num(n_lat2_s2), .quo(h_lat2));

	// Restore the sign of the half-angle differences.
	always_comb begin
		ang_dlat = ctl_q[DIV_OUT].dlat_neg ? -$signed({2'b00, h_dlat}) : $signed({2'b00, h_dlat});
		ang_dlon = ctl_q[DIV_OUT].dlon_neg ? -$signed({2'b00, h_dlon}) : $signed({2'b00, h_dlon});
		ang_lat1 = $signed({2'b00, h_lat1});
		ang_lat2 = $signed({2'b00, h_lat2});
	end

	hvd_rot #(.STAGES(STAGES)) u_rot_dlat (.clk, .ang(ang_dlat), .sn(sn_dlat), .cs());
	hvd_rot #(.STAGES(STAGES)) u_rot_dlon (.clk, .ang(ang_dlon), .sn(sn_dlon), .cs());
	hvd_rot #(.STAGES(STAGES)) u_rot_lat1 (.clk, .ang(ang_lat1), .sn(), .cs(cs_lat1));
	hvd_rot #(.STAGES(STAGES)) u_rot_lat2 (.clk, .ang(ang_lat2), .sn(), .cs(cs_lat2));

	// Latitudes past a quarter turn take the negated supplementary cosine.
	always_comb begin
		c1 = ctl_q[ROT_OUT].flip1 ? -cs_lat1 : cs_lat1;
		c2 = ctl_q[ROT_OUT].flip2 ? -cs_lat2 : cs_lat2;
		a_sum = 35'(s1sq_s2) + 35'(t_s2);
	end

	// Products, then the sum and its clamp.
	always_ff @(posedge clk) begin
		s1sq_s1 <= hvd_pkg::mul_q30(sn_dlat, sn_dlat);
		s2sq_s1 <= hvd_pkg::mul_q30(sn_dlon, sn_dlon);
		cc_s1   <= hvd_pkg::mul_q30(c1, c2);
		s1sq_s2 <= s1sq_s1;
		t_s2    <= hvd_pkg::mul_q30(cc_s1, s2sq_s1);
		priority if (a_sum < 0)                             a_s3 <= '0;
		else if (a_sum > 35'(hvd_pkg::ONE_Q30))             a_s3 <= hvd_pkg::ONE_Q30;
		else                                                a_s3 <= a_sum[30:0];
	end

	assign push  = ctl_q[FL-1].valid;
	assign a_q30 = a_s3;

endmodule

FILE: sv/hvd_queue.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - decoupling queue
// Short FIFO carrying the haversine term from the front end to the back end.
// The read data is registered and holds the entry taken at the last pop.
// ---------------------------------------------------------------------------
`include "haversine_distance_unit_defines.svh"

module hvd_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [30:0] wdata,
	input  logic        pop,
	output logic        not_empty,
	output logic        full,
	output logic [30:0] rdata
);

	logic [30:0]                  mem_q [0:hvd_pkg::QUEUE_DEPTH-1];
	logic [30:0]                  rdata_q;
	logic [hvd_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [hvd_pkg::QUEUE_AW:0]   count_q;

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage, with the read registered on a pop.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
		if (pop)  rdata_q <= mem_q[rd_ptr_q];
	end

	assign rdata     = rdata_q;
	assign not_empty = count_q != '0;
	assign full      = count_q == (hvd_pkg::QUEUE_AW+1)'(hvd_pkg::QUEUE_DEPTH);

	`HVD_ASSERT(a_no_overflow, clk, arst_n, push, !full || pop, "queue written while full")
	`HVD_ASSERT(a_drain, clk, arst_n, not_empty, pop, "queued request left waiting")
	`HVD_ASSERT(a_no_underflow, clk, arst_n, pop, not_empty, "queue read while empty")
	`HVD_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "occupancy did not rise")

endmodule

FILE: sv/hvd_back.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - back end
// Square roots of a and 1-a, vectoring CORDIC for the central angle, and the
// scaling by the sphere radius into millimetres.
// ---------------------------------------------------------------------------
module hvd_back #(
	parameter int STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop,
	input  logic [30:0] a_q30,
	input  logic [22:0] radius,
	output logic        done,
	output logic [34:0] distance_mm
);

	localparam int SQ  = hvd_pkg::SQRT_STEPS;
	localparam int BL  = SQ + STAGES + 3;

	logic [BL-1:0] vld_q;

	logic [60:0] na_s [0:SQ];
	logic [60:0] ra_s [0:SQ];
	logic [60:0] nb_s [0:SQ];
	logic [60:0] rb_s [0:SQ];

	hvd_pkg::ang_t x_s [0:STAGES];
	hvd_pkg::ang_t y_s [0:STAGES];
	hvd_pkg::ang_t z_s [0:STAGES];

	logic [31:0] c2;
	logic [54:0] p_s;
	logic [35:0] mm;
	logic [34:0] mm_s;

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BL-2:0], pop};
		end
	end

	// Operands of the two square roots, from the registered queue output.
	assign na_s[0] = {a_q30[30:0], 30'd0};
	assign nb_s[0] = {31'(hvd_pkg::ONE_Q30 - a_q30), 30'd0};
	assign ra_s[0] = '0;
	assign rb_s[0] = '0;

	// Floor square root, two radicand bits per stage.
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [60:0] BIT = 61'(1) << (60 - 2*k);
		logic [60:0] ta, tb;

		assign ta = ra_s[k] + BIT;
		assign tb = rb_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (na_s[k] >= ta) begin
				na_s[k+1] <= na_s[k] - ta;
				ra_s[k+1] <= (ra_s[k] >> 1) + BIT;
			end else begin
				na_s[k+1] <= na_s[k];
				ra_s[k+1] <= ra_s[k] >> 1;
			end
			if (nb_s[k] >= tb) begin
				nb_s[k+1] <= nb_s[k] - tb;
				rb_s[k+1] <= (rb_s[k] >> 1) + BIT;
			end else begin
				nb_s[k+1] <= nb_s[k];
				rb_s[k+1] <= rb_s[k] >> 1;
			end
		end
	end

	// Vectoring CORDIC: x from sqrt(1-a), y from sqrt(a).
	assign x_s[0] = $signed({3'b000, rb_s[SQ][30:0]});
	assign y_s[0] = $signed({3'b000, ra_s[SQ][30:0]});
	assign z_s[0] = '0;

	for (genvar i = 0; i < STAGES; i++) begin : g_vec
		hvd_pkg::ang_t at;

		assign at = $signed({2'b00, hvd_pkg::atan_q30(5'(i))});

		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + at;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - at;
			end
		end
	end

	// Central angle, scaling and the rounded conversion to millimetres.
	always_comb begin
		c2 = (z_s[STAGES] < 0) ? '0 : {z_s[STAGES][30:0], 1'b0};
		mm = 36'(p_s[54:30]) * 36'd1000
			+ 36'((40'(p_s[29:0]) * 40'd1000 + 40'd536870912) >> 30);
	end

	always_ff @(posedge clk) begin
		p_s  <= 55'(radius) * 55'(c2);
		mm_s <= (mm > 36'(hvd_pkg::OUT_MAX)) ? hvd_pkg::OUT_MAX : mm[34:0];
	end

	assign done        = vld_q[BL-1];
	assign distance_mm = mm_s;

endmodule

FILE: sv/haversine_distance_unit.sv
// ---------------------------------------------------------------------------
// Haversine distance unit - top level
// Great-circle distance between two positions, in millimetres.
// ---------------------------------------------------------------------------
// Usage:
// A request is taken on a rising edge where start is high and busy is low.
// The four coordinate ports are in units of 1e-7 degree, north and east
// positive. The result appears on distance_mm for a single cycle, flagged by
// distance_valid; there is no way to hold it off, so the receiver must take it.
// The result path runs through the four-stage reciprocal dividers and CORDIC
// pipelines in the front end, the queue, and the 31-step square roots and
// vectoring CORDIC in the back end.
// One request is taken every cycle; busy rises only if the decoupling queue
// fills, which the back end prevents by draining every cycle.
// The sphere radius is written through earth_radius_we and earth_radius_m;
// the user must write it only while no request is in flight, which the block
// itself does not enforce. It resets to 6371000 metres.
// Reset clears all control state and empties the pipelines and the queue.
// ---------------------------------------------------------------------------
module haversine_distance_unit #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	input  logic               earth_radius_we,
	input  logic [22:0]        earth_radius_m,
	output logic               distance_valid,
	output logic [34:0]        distance_mm
);

	logic        accept;
	logic        push, pop, not_empty, full;
	logic [30:0] a_front, a_back;
	logic [22:0] radius_q;

	// Radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
		end else if (earth_radius_we) begin
			radius_q <= earth_radius_m;
		end
	end

	assign accept = start & ~full;
	assign busy   = full;
	assign pop    = not_empty;

	hvd_front #(.STAGES(CORDIC_STAGES)) u_front (
		.clk, .arst_n, .accept,
		.first_latitude, .first_longitude, .second_latitude, .second_longitude,
		.push, .a_q30(a_front)
	);

	hvd_queue u_queue (
		.clk, .arst_n, .push, .wdata(a_front), .pop,
		.not_empty, .full, .rdata(a_back)
	);

	hvd_back #(.STAGES(CORDIC_STAGES)) u_back (
		.clk, .arst_n, .pop, .a_q30(a_back), .radius(radius_q),
		.done(distance_valid), .distance_mm
	);

endmodule
